FILE: sv/gde_pkg.sv
// Shared constants for the gain duck envelope: widths, register indices, request kinds.
package gde_pkg;

   // Gain format and unity value (Q1.15)
   localparam int GAIN_W = 16;
   localparam logic [GAIN_W-1:0] UNITY = 16'd32768;

   // Register and tick widths
   localparam int REG_W = 16;
   localparam int TICK_W = 16;
   localparam int TIME_BITS_DEF = 16;

   // Configuration register indices
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DUCK_LEVEL = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ATTACK_TIME = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD_TIME = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELEASE_TIME = 2'd3;

   // Request kinds carried on tuser
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_START = 1'b1;

   // Serial divider: one quotient bit per cycle
   localparam int DIV_BITS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_BITS);

   // Beat widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

endpackage

FILE: sv/gain_duck_envelope.sv
// Attack-hold-release ducking gain envelope with a bit-serial ramp divider.
//
//   channel  ports       payload (low bit first)
//   -------  ----------  ------------------------------------------------
//   request  req_t*      tdata: tick_ms[15:0]; tuser: req_type
//   result   rsp_t*      tdata: duck_gain[15:0], duck_active[16], zero pad
//   config   csr_*       csr_addr picks level/attack/hold/release
//
// A start beat or a tick while disarmed goes straight to the output state; a
// tick that lands in hold or ends the release first passes the classify state.
// A tick on a ramp passes classify, multiply, divide and finish: the restoring
// divider produces one quotient bit per cycle, 16 bits in all, after one multiply.
// One request is in flight at a time; a result waiting in the output
// register does not block the next request, only the final write-back.
// Synchronous reset clears the envelope state and restores register defaults.
module gain_duck_envelope
   import gde_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] tick_ms
   input  logic                  req_tuser,   // [0] req_type
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] duck_gain, [16] duck_active
   // configuration port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [REG_W-1:0]      csr_wdata
);

   localparam int EW = TIME_BITS + 2;              // elapsed width
   localparam int SW = (EW > TICK_W) ? EW : TICK_W;  // tick sum width, without its carry bit
   localparam int CW = (EW > REG_W + 1) ? EW + 1 : REG_W + 2;  // compare width

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLASS = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [REG_W-1:0]     level_ff, attack_ff, hold_ff, release_ff;
   logic [EW-1:0]        elapsed_ff, elapsed_in;
   logic                 armed_ff, armed_in;
   logic [GAIN_W-1:0]    gain_ff, gain_in;
   logic [REG_W:0]       hend_ff, hend_in;
   logic                 is_attack_ff, is_attack_in;
   logic [REG_W-1:0]     num_ff, num_in;
   logic [REG_W-1:0]     den_ff, den_in;
   logic [REG_W-1:0]     rem_ff, rem_in;
   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [GAIN_W-1:0]    level_clamped;
   logic [GAIN_W-1:0]    depth;
   logic [SW:0]          sum;
   logic [CW-1:0]        e_x, a_x, hend_x, rel_x, r_x;
   logic [2*REG_W-1:0]   prod;
   logic [REG_W:0]       trial;
   logic                 out_free;

   assign level_clamped = (level_ff > UNITY) ? UNITY : level_ff;
   assign depth = UNITY - level_clamped;
   assign sum = (SW + 1)'(elapsed_ff) + (SW + 1)'(req_tdata[TICK_W-1:0]);
   assign e_x = CW'(elapsed_ff);
   assign a_x = CW'(attack_ff);
   assign hend_x = CW'(hend_ff);
   assign rel_x = e_x - hend_x;
   assign r_x = CW'(release_ff);
   assign prod = depth * num_ff;
   assign trial = {rem_ff, quo_ff[DIV_BITS-1]} - {1'b0, den_ff};
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      elapsed_in = elapsed_ff;
      armed_in = armed_ff;
      gain_in = gain_ff;
      hend_in = hend_ff;
      is_attack_in = is_attack_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == REQ_START) begin
                  elapsed_in = '0;
                  armed_in = (attack_ff | hold_ff | release_ff) != '0;
                  if (attack_ff == '0) begin
                     gain_in = level_clamped;
                  end
                  state_in = ST_OUT;
               end else if (armed_ff) begin
                  // saturate the elapsed time at its all-ones value
                  elapsed_in = (sum[SW:EW] != '0) ? '1 : sum[EW-1:0];
                  hend_in = {1'b0, attack_ff} + {1'b0, hold_ff};
                  state_in = ST_CLASS;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_CLASS: begin
            if (e_x <= a_x) begin
               if (attack_ff == '0) begin
                  gain_in = level_clamped;
                  state_in = ST_OUT;
               end else begin
                  is_attack_in = 1'b1;
                  num_in = e_x[REG_W-1:0];
                  den_in = attack_ff;
                  state_in = ST_MUL;
               end
            end else if (e_x <= hend_x) begin
               gain_in = level_clamped;
               state_in = ST_OUT;
            end else if (rel_x >= r_x) begin
               // release finished: disarm and return to unity
               armed_in = 1'b0;
               elapsed_in = '0;
               gain_in = UNITY;
               state_in = ST_OUT;
            end else begin
               is_attack_in = 1'b0;
               num_in = rel_x[REG_W-1:0];
               den_in = release_ff;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // high half is below the divisor since the quotient fits 16 bits
            rem_in = prod[2*REG_W-1:REG_W];
            quo_in = prod[REG_W-1:0];
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!trial[REG_W]) begin
               rem_in = trial[REG_W-1:0];
            end else begin
               rem_in = {rem_ff[REG_W-2:0], quo_ff[DIV_BITS-1]};
            end
            quo_in = {quo_ff[DIV_BITS-2:0], !trial[REG_W]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_BITS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (is_attack_ff) begin
               gain_in = UNITY - quo_ff;
            end else begin
               gain_in = level_clamped + quo_ff;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the result register drains
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {{(RSP_DATA_W - GAIN_W - 1){1'b0}}, armed_ff, gain_ff};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         elapsed_ff <= '0;
         armed_ff <= 1'b0;
         gain_ff <= UNITY;
         rsp_valid_ff <= 1'b0;
         level_ff <= UNITY;
         attack_ff <= '0;
         hold_ff <= '0;
         release_ff <= '0;
      end else begin
         state_ff <= state_in;
         elapsed_ff <= elapsed_in;
         armed_ff <= armed_in;
         gain_ff <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_DUCK_LEVEL:   level_ff <= csr_wdata;
               CSR_ATTACK_TIME:  attack_ff <= csr_wdata;
               CSR_HOLD_TIME:    hold_ff <= csr_wdata;
               CSR_RELEASE_TIME: release_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      hend_ff <= hend_in;
      is_attack_ff <= is_attack_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
